FILE: rtl/core/jdc_pkg.sv
// Shared constants, types and tables for the Julian Date to calendar converter.
// Depends on nothing; every other file of the block imports it.
package jdc_pkg;

    localparam int DAY_BITS   = 23;
    localparam int FRAC_BITS  = 32;
    localparam int Z_W        = DAY_BITS + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int unsigned GREG_START = 2299161;

    // alpha = (4z - 7468865) / 146097
    localparam int unsigned A_OFS   = 7468865;
    localparam int unsigned A_DIV   = 146097;
    localparam int          NA_W    = DAY_BITS + 3;
    localparam int          SA      = NA_W;
    localparam int          MA_W    = NA_W - 17;
    localparam longint unsigned MA  = (64'd1 << SA) / A_DIV;
    localparam int          PA_W    = NA_W + MA_W;
    localparam int          ALPHA_W = NA_W - 17;
    localparam int          RA_W    = 19;

    localparam int unsigned C_JUL   = 1524;
    localparam int unsigned C_GREG  = 1525;

    // d = (20c - 2442) / 7305
    localparam int unsigned D_OFS   = 2442;
    localparam int unsigned D_DIV   = 7305;
    localparam int          ND_W    = DAY_BITS + 5;
    localparam int          SD      = ND_W;
    localparam int          MD_W    = ND_W - 12;
    localparam longint unsigned MD  = (64'd1 << SD) / D_DIV;
    localparam int          PD_W    = ND_W + MD_W;
    localparam int          D_W     = ND_W - 12;
    localparam int          RD_W    = 14;

    // f = 10000x / 306001
    localparam int          X_W     = 9;
    localparam int unsigned F_SCALE = 10000;
    localparam int unsigned F_DIV   = 306001;
    localparam int          NF_W    = 23;
    localparam int          SF      = NF_W;
    localparam longint unsigned MF  = (64'd1 << SF) / F_DIV;
    localparam longint unsigned MF10 = MF * F_SCALE;
    localparam int          PF_W    = X_W + 19;
    localparam int          F_W     = 5;
    localparam int          RF_W    = 20;

    localparam int unsigned YEAR_OFS = 4715;

    localparam int T1_W = FRAC_BITS + 5;
    localparam int T2_W = FRAC_BITS + 6;

    typedef struct packed {
        logic                 zero;
        logic                 greg;
        logic [Z_W-1:0]       z;
        logic [FRAC_BITS-1:0] fod;
    } t_front_item;

    typedef struct packed {
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [15:0] sf;
    } t_tod;

    // floor(30.6001 * f)
    function automatic logic [9:0] mul_30_6001(input logic [F_W-1:0] f);
        logic [9:0] v;
        unique case (f)
            5'd0:  v = 10'd0;
            5'd1:  v = 10'd30;
            5'd2:  v = 10'd61;
            5'd3:  v = 10'd91;
            5'd4:  v = 10'd122;
            5'd5:  v = 10'd153;
            5'd6:  v = 10'd183;
            5'd7:  v = 10'd214;
            5'd8:  v = 10'd244;
            5'd9:  v = 10'd275;
            5'd10: v = 10'd306;
            5'd11: v = 10'd336;
            5'd12: v = 10'd367;
            5'd13: v = 10'd397;
            5'd14: v = 10'd428;
            5'd15: v = 10'd459;
            5'd16: v = 10'd489;
            5'd17: v = 10'd520;
            5'd18: v = 10'd550;
            5'd19: v = 10'd581;
            5'd20: v = 10'd612;
            5'd21: v = 10'd642;
            5'd22: v = 10'd673;
            5'd23: v = 10'd703;
            5'd24: v = 10'd734;
            5'd25: v = 10'd765;
            5'd26: v = 10'd795;
            5'd27: v = 10'd826;
            5'd28: v = 10'd856;
            5'd29: v = 10'd887;
            5'd30: v = 10'd918;
            5'd31: v = 10'd948;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/jdc_stream_if.sv
// Valid/ready stream interfaces for the converter's input and result channels.
// Depends on jdc_pkg for field widths.
interface jdc_in_if;
    import jdc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DAY_BITS-1:0]  jd_day;
    logic [FRAC_BITS-1:0] jd_fraction;
    modport source (output valid, jd_day, jd_fraction, input ready);
    modport sink   (input valid, jd_day, jd_fraction, output ready);
endinterface

interface jdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [15:0]        second_fraction;
    modport source (output valid, year, month, day_of_month, hour, minute, second,
                    second_fraction, input ready);
    modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                    second_fraction, output ready);
endinterface

FILE: rtl/core/jdc_front.sv
// Front end: accepts a Julian Date, rounds to the civil day and classifies it.
// Depends on jdc_pkg and jdc_in_if.
module jdc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    jdc_in_if.sink              i_jd,
    output logic                o_valid,
    input  logic                i_ready,
    output jdc_pkg::t_front_item o_item
);
    import jdc_pkg::*;

    logic        r_valid;
    t_front_item r_item;
    t_front_item n_item;
    logic        half;
    logic        accept;

    assign i_jd.ready = !r_valid || i_ready;
    assign accept     = i_jd.valid && i_jd.ready;
    assign half       = i_jd.jd_fraction[FRAC_BITS-1];

    always_comb begin
        n_item.z    = {1'b0, i_jd.jd_day} + Z_W'(half);
        n_item.fod  = {~half, i_jd.jd_fraction[FRAC_BITS-2:0]};
        n_item.zero = (i_jd.jd_day == '0) && (i_jd.jd_fraction == '0);
        n_item.greg = n_item.z >= Z_W'(GREG_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/jdc_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on jdc_pkg for the item type and depth.
module jdc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  jdc_pkg::t_front_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output jdc_pkg::t_front_item o_item
);
    import jdc_pkg::*;

    t_front_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 push;
    logic                 pop;

    assign o_ready = r_count != (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count above depth");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count not decremented on pop");
`endif

endmodule

FILE: rtl/core/jdc_back.sv
// Back end: pipelined calendar arithmetic with constant reciprocal divisions.
// Depends on jdc_pkg and jdc_out_if.
module jdc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  jdc_pkg::t_front_item i_item,
    jdc_out_if.source            o_cal
);
    import jdc_pkg::*;

    localparam int NSTG = 10;

    logic            en;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_zero;
    t_tod            r_tod [NSTG-3];

    logic [NA_W-1:0]    r_s1_na;
    logic [PA_W-1:0]    r_s1_pa;
    logic [Z_W-1:0]     r_s1_z;
    logic               r_s1_greg;
    logic [T1_W-1:0]    r_s1_t1;

    logic [ALPHA_W-1:0] r_s2_q;
    logic [RA_W-1:0]    r_s2_r;
    logic [Z_W-1:0]     r_s2_z;
    logic               r_s2_greg;
    logic [4:0]         r_s2_hr;
    logic [T2_W-1:0]    r_s2_t2;

    logic [Z_W-1:0]     r_s3_c;
    logic [ND_W-1:0]    r_s3_nd;
    logic [4:0]         r_s3_hr;
    logic [5:0]         r_s3_mn;
    logic [T2_W-1:0]    r_s3_t3;

    logic [Z_W-1:0]     r_s4_c;
    logic [ND_W-1:0]    r_s4_nd;
    logic [PD_W-1:0]    r_s4_pd;

    logic [Z_W-1:0]     r_s5_c;
    logic [D_W-1:0]     r_s5_q;
    logic [RD_W-1:0]    r_s5_r;

    logic [Z_W-1:0]     r_s6_c;
    logic [D_W-1:0]     r_s6_d;

    logic [D_W-1:0]     r_s7_d;
    logic [X_W-1:0]     r_s7_x;

    logic [D_W-1:0]     r_s8_d;
    logic [X_W-1:0]     r_s8_x;
    logic [NF_W-1:0]    r_s8_nf;
    logic [PF_W-1:0]    r_s8_pf;

    logic [D_W-1:0]     r_s9_d;
    logic [X_W-1:0]     r_s9_x;
    logic [F_W-1:0]     r_s9_q;
    logic [RF_W-1:0]    r_s9_r;

    logic [D_W-1:0]     r_s10_d;
    logic [X_W-1:0]     r_s10_x;
    logic [F_W-1:0]     r_s10_f;

    logic               r_out_valid;
    logic signed [15:0] r_out_year;
    logic [3:0]         r_out_month;
    logic [4:0]         r_out_dom;
    t_tod               r_out_tod;

    logic [NA_W-1:0]    n_s1_na;
    logic [ALPHA_W-1:0] n_s2_q;
    logic [NA_W-1:0]    s2_rem;
    logic [ALPHA_W-1:0] s3_alpha;
    logic [Z_W-1:0]     n_s3_c;
    t_tod               n_s4_tod;
    logic [D_W-1:0]     n_s5_q;
    logic [ND_W-1:0]    s5_rem;
    logic [Z_W-1:0]     s7_e;
    logic [Z_W-1:0]     s7_x;
    logic [F_W-1:0]     n_s9_q;
    logic [NF_W-1:0]    s9_rem;
    logic [9:0]         s11_dom;
    logic [F_W-1:0]     s11_k12;
    logic [F_W-1:0]     s11_mon;
    logic [15:0]        s11_year;

    assign en      = !r_out_valid || o_cal.ready;
    assign o_ready = en;

    always_comb begin
        n_s1_na  = {i_item.z, 2'b00} - NA_W'(A_OFS);
        n_s2_q   = ALPHA_W'(r_s1_pa >> SA);
        s2_rem   = r_s1_na - NA_W'(n_s2_q) * NA_W'(A_DIV);
        s3_alpha = r_s2_q + ALPHA_W'(r_s2_r >= RA_W'(A_DIV));
        if (r_s2_greg) begin
            n_s3_c = r_s2_z + Z_W'(s3_alpha) - Z_W'(s3_alpha >> 2) + Z_W'(C_GREG);
        end else begin
            n_s3_c = r_s2_z + Z_W'(C_JUL);
        end
        n_s4_tod.hr = r_s3_hr;
        n_s4_tod.mn = r_s3_mn;
        n_s4_tod.sc = r_s3_t3[T2_W-1:FRAC_BITS];
        n_s4_tod.sf = r_s3_t3[FRAC_BITS-1:FRAC_BITS-16];
        n_s5_q   = D_W'(r_s4_pd >> SD);
        s5_rem   = r_s4_nd - ND_W'(n_s5_q) * ND_W'(D_DIV);
        s7_e     = Z_W'(r_s6_d) * Z_W'(365) + Z_W'(r_s6_d >> 2);
        s7_x     = r_s6_c - s7_e;
        n_s9_q   = F_W'(r_s8_pf >> SF);
        s9_rem   = r_s8_nf - NF_W'(n_s9_q) * NF_W'(F_DIV);
        s11_dom  = 10'(r_s10_x) - mul_30_6001(r_s10_f);
        priority if (r_s10_f >= F_W'(28)) begin
            s11_k12 = F_W'(24);
        end else if (r_s10_f >= F_W'(14)) begin
            s11_k12 = F_W'(12);
        end else begin
            s11_k12 = '0;
        end
        s11_mon  = r_s10_f - F_W'(1) - s11_k12;
        s11_year = 16'(r_s10_d) - 16'(YEAR_OFS) - 16'(s11_mon >= F_W'(3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NSTG-2:0], i_valid};
            r_out_valid <= r_vld[NSTG-1];
        end
        if (en) begin
            r_zero    <= {r_zero[NSTG-2:0], i_item.zero};

            r_s1_na   <= n_s1_na;
            r_s1_pa   <= PA_W'(n_s1_na) * PA_W'(MA);
            r_s1_z    <= i_item.z;
            r_s1_greg <= i_item.greg;
            r_s1_t1   <= T1_W'(i_item.fod) * T1_W'(24);

            r_s2_q    <= n_s2_q;
            r_s2_r    <= s2_rem[RA_W-1:0];
            r_s2_z    <= r_s1_z;
            r_s2_greg <= r_s1_greg;
            r_s2_hr   <= r_s1_t1[T1_W-1:FRAC_BITS];
            r_s2_t2   <= T2_W'(r_s1_t1[FRAC_BITS-1:0]) * T2_W'(60);

            r_s3_c    <= n_s3_c;
            r_s3_nd   <= ND_W'(n_s3_c) * ND_W'(20) - ND_W'(D_OFS);
            r_s3_hr   <= r_s2_hr;
            r_s3_mn   <= r_s2_t2[T2_W-1:FRAC_BITS];
            r_s3_t3   <= T2_W'(r_s2_t2[FRAC_BITS-1:0]) * T2_W'(60);

            r_tod[0]  <= n_s4_tod;
            for (int i = 1; i < NSTG - 3; i++) begin
                r_tod[i] <= r_tod[i-1];
            end

            r_s4_c    <= r_s3_c;
            r_s4_nd   <= r_s3_nd;
            r_s4_pd   <= PD_W'(r_s3_nd) * PD_W'(MD);

            r_s5_c    <= r_s4_c;
            r_s5_q    <= n_s5_q;
            r_s5_r    <= s5_rem[RD_W-1:0];

            r_s6_c    <= r_s5_c;
            r_s6_d    <= r_s5_q + D_W'(r_s5_r >= RD_W'(D_DIV));

            r_s7_d    <= r_s6_d;
            r_s7_x    <= s7_x[X_W-1:0];

            r_s8_d    <= r_s7_d;
            r_s8_x    <= r_s7_x;
            r_s8_nf   <= NF_W'(r_s7_x) * NF_W'(F_SCALE);
            r_s8_pf   <= PF_W'(r_s7_x) * PF_W'(MF10);

            r_s9_d    <= r_s8_d;
            r_s9_x    <= r_s8_x;
            r_s9_q    <= n_s9_q;
            r_s9_r    <= s9_rem[RF_W-1:0];

            r_s10_d   <= r_s9_d;
            r_s10_x   <= r_s9_x;
            r_s10_f   <= r_s9_q + F_W'(r_s9_r >= RF_W'(F_DIV));

            if (r_zero[NSTG-1]) begin
                r_out_year  <= '0;
                r_out_month <= '0;
                r_out_dom   <= '0;
                r_out_tod   <= '0;
            end else begin
                r_out_year  <= signed'(s11_year);
                r_out_month <= s11_mon[3:0];
                r_out_dom   <= s11_dom[4:0];
                r_out_tod   <= r_tod[NSTG-4];
            end
        end
    end

    assign o_cal.valid           = r_out_valid;
    assign o_cal.year            = r_out_year;
    assign o_cal.month           = r_out_month;
    assign o_cal.day_of_month    = r_out_dom;
    assign o_cal.hour            = r_out_tod.hr;
    assign o_cal.minute          = r_out_tod.mn;
    assign o_cal.second          = r_out_tod.sc;
    assign o_cal.second_fraction = r_out_tod.sf;

`ifndef NO_ASSERTIONS
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> o_cal.month <= 4'd12)
        else $error("month out of range");
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> o_cal.hour <= 5'd23 && o_cal.minute <= 6'd59
                        && o_cal.second <= 6'd59)
        else $error("time of day out of range");
    a_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid && o_cal.month == 4'd0 |-> o_cal.day_of_month == 5'd0
                                               && o_cal.year == 16'sd0)
        else $error("partial zero date");
`endif

endmodule

FILE: rtl/core/julian_date_to_calendar.sv
// Julian Date to calendar date and time of day, one item per cycle unless the output stalls.
// An accepted item passes through the front register, the queue and the back end pipeline stages.
// Throughput: one item per cycle unless the output stalls; the back end is fully pipelined.
// A four-entry queue decouples the front end from output stalls.
// Reset (synchronous, active low) empties the front register, queue and pipeline.
module julian_date_to_calendar (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jdc_in_if.sink     i_jd,
    jdc_out_if.source  o_cal
);
    import jdc_pkg::*;

    logic        front_valid;
    logic        front_ready;
    t_front_item front_item;
    logic        queue_valid;
    logic        queue_ready;
    t_front_item queue_item;

    jdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jd    (i_jd),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    jdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    jdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_item  (queue_item),
        .o_cal   (o_cal)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for julian_date_to_calendar: random-paced valid/ready traffic,
// with each item's calendar date and time of day predicted in exact fixed point.
// Depends on jdc_pkg, jdc_in_if, jdc_out_if and the julian_date_to_calendar RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned DAY_MAX = (1 << DAY_BITS) - 1;
    localparam logic [FRAC_BITS-1:0] HALF_DAY = 1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic [DAY_BITS-1:0]  day;
        logic [FRAC_BITS-1:0] frac;
    } t_jd_item;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         dom;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [15:0]        sfrac;
    } t_cal;

    logic i_clk;
    logic i_rst_n;

    jdc_in_if  jd_bus ();
    jdc_out_if cal_bus ();

    julian_date_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jd    (jd_bus),
        .o_cal   (cal_bus)
    );

    t_jd_item pending_dates[$];
    t_cal     expected_cal[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       results_seen = 0;
    bit       in_taken = 0;
    int       send_gap = 0;
    int       send_quiet = 0;
    int       recv_stall = 0;
    int       recv_quiet = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Meeus conversion, every quotient floored
    function automatic t_cal to_calendar(input logic [DAY_BITS-1:0] day,
                                         input logic [FRAC_BITS-1:0] frac);
        longint unsigned z, c, d, e, f, mon, dom, alpha;
        longint          yr;
        logic [FRAC_BITS-1:0] fod;
        logic [63:0]     t;
        t_cal            r;
        r = '0;
        if (day == 0 && frac == 0)
            return r;
        z = longint'(day) + (frac[FRAC_BITS-1] ? 1 : 0);
        fod = frac + HALF_DAY;
        if (z < GREG_START) begin
            c = z + 1524;
        end else begin
            alpha = (4 * z - 7468865) / 146097;
            c = z + alpha - alpha / 4 + 1525;
        end
        d = (20 * c - 2442) / 7305;
        e = 365 * d + d / 4;
        f = ((c - e) * 10000) / 306001;
        dom = c - e - (f * 306001) / 10000;
        mon = f - 1 - 12 * (f / 14);
        yr = longint'(d) - 4715 - longint'((7 + mon) / 10);
        r.year  = yr[15:0];
        r.month = mon[3:0];
        r.dom   = dom[4:0];
        t = 64'(fod) * 24;
        r.hour = t[FRAC_BITS+4:FRAC_BITS];
        t = 64'(t[FRAC_BITS-1:0]) * 60;
        r.minute = t[FRAC_BITS+5:FRAC_BITS];
        t = 64'(t[FRAC_BITS-1:0]) * 60;
        r.second = t[FRAC_BITS+5:FRAC_BITS];
        r.sfrac = t[FRAC_BITS-1:FRAC_BITS-16];
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones, and idle-free stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    endtask

    task automatic add_date(input int unsigned day, input logic [FRAC_BITS-1:0] frac);
        t_jd_item it;
        it.day = DAY_BITS'(day);
        it.frac = frac;
        pending_dates.push_back(it);
    endtask

    task automatic add_random(input int n);
        int unsigned          day;
        logic [FRAC_BITS-1:0] frac;
        int kind;
        repeat (n) begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                day = $urandom_range(0, DAY_MAX);
            else if (kind < 60)
                day = $urandom_range(GREG_START - 2000, GREG_START + 2000);
            else if (kind < 75)
                day = $urandom_range(2400000, 2500000);
            else if (kind < 85)
                day = $urandom_range(0, 3000);
            else if (kind < 95)
                day = $urandom_range(DAY_MAX - 3000, DAY_MAX);
            else
                day = $urandom_range(1721000, 1722500);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                frac = $urandom;
            end else if (kind < 80) begin
                frac = 32'h7FFF_0000 + $urandom_range(0, 32'h1_FFFF);
            end else if (kind < 90) begin
                case ($urandom_range(0, 3))
                    0: frac = '0;
                    1: frac = '1;
                    2: frac = HALF_DAY;
                    default: frac = HALF_DAY - 1;
                endcase
            end else begin
                frac = $urandom_range(0, 32'h0000_FFFF);
            end
            add_date(day, frac);
        end
    endtask

    task automatic drain();
        while (pending_dates.size() != 0 || jd_bus.valid || expected_cal.size() != 0)
            @(posedge i_clk);
    endtask

    // input side: hold until taken, then advance after a random gap
    always @(negedge i_clk) begin
        t_jd_item nxt;
        if (!i_rst_n) begin
            jd_bus.valid       <= 1'b0;
            jd_bus.jd_day      <= '0;
            jd_bus.jd_fraction <= '0;
        end else if (!jd_bus.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                jd_bus.valid <= 1'b0;
            end else if (pending_dates.size() != 0) begin
                nxt = pending_dates.pop_front();
                jd_bus.jd_day      <= nxt.day;
                jd_bus.jd_fraction <= nxt.frac;
                jd_bus.valid       <= 1'b1;
                send_gap = pick_gap(send_quiet);
            end else begin
                jd_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cal_bus.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            cal_bus.ready <= 1'b0;
        end else begin
            cal_bus.ready <= 1'b1;
            recv_stall = pick_gap(recv_quiet);
        end
    end

    always @(posedge i_clk) begin
        t_cal got;
        t_cal want;
        cycles++;
        in_taken = i_rst_n && jd_bus.valid && jd_bus.ready;
        if (in_taken)
            expected_cal.push_back(to_calendar(jd_bus.jd_day, jd_bus.jd_fraction));
        if (i_rst_n && cal_bus.valid && cal_bus.ready) begin
            got.year   = cal_bus.year;
            got.month  = cal_bus.month;
            got.dom    = cal_bus.day_of_month;
            got.hour   = cal_bus.hour;
            got.minute = cal_bus.minute;
            got.second = cal_bus.second;
            got.sfrac  = cal_bus.second_fraction;
            if (expected_cal.size() == 0) begin
                report($sformatf("unexpected result year %0d month %0d day %0d",
                                 got.year, got.month, got.dom));
            end else begin
                want = expected_cal.pop_front();
                check_field("year", got.year, want.year);
                check_field("month", got.month, want.month);
                check_field("day_of_month", got.dom, want.dom);
                check_field("hour", got.hour, want.hour);
                check_field("minute", got.minute, want.minute);
                check_field("second", got.second, want.second);
                check_field("second_fraction", got.sfrac, want.sfrac);
            end
            results_seen++;
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_date(0, 0);
        add_date(0, 1);
        add_date(0, HALF_DAY - 1);
        add_date(0, HALF_DAY);
        add_date(0, '1);
        add_date(1, 0);
        add_date(GREG_START - 1, 0);
        add_date(GREG_START - 1, HALF_DAY - 1);
        add_date(GREG_START - 1, HALF_DAY);
        add_date(GREG_START, 0);
        add_date(GREG_START, '1);
        add_date(1721423, HALF_DAY);
        add_date(2415079, HALF_DAY);
        add_date(2451544, HALF_DAY);
        add_date(2451545, 0);
        add_date(2451604, HALF_DAY);
        add_date(123456, 32'hAAAA_AAAA);
        add_date(4194304, 32'h5555_5555);
        add_date(7654321, 32'h1234_5678);
        add_date(DAY_MAX, 0);
        add_date(DAY_MAX, '1);
        drain();

        add_random(600);
        drain();
        add_random(550);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cal.size() != 0)
            report($sformatf("%0d results never arrived", expected_cal.size()));
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
